[rtl/core/ddsr_pkg.sv]
// Shared types and constants for the differential-drive stepper ramp unit.
// No dependencies; imported by every module of the block.
package ddsr_pkg;

  localparam int TICKS_PER_SECOND = 1000000;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int SPD_W      = 12;
  localparam int CUR_W      = 13;
  localparam int ACC_W      = 8;
  localparam int RP_W       = 16;
  localparam int SPM_W      = 8;
  localparam int MIN_W      = 8;
  localparam int WD_W       = 24;
  localparam int STEP_CNT_W = 20;

  // Ramp arithmetic headroom
  localparam int RAMP_W = CUR_W + 2;

  // Configuration port
  localparam int NUM_REGS  = 5;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_ACCEL    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_RAMP     = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_SPM      = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MIN      = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_WATCHDOG = REG_IDX_W'(4);

  localparam logic [ACC_W-1:0] ACCEL_RST    = ACC_W'(2);
  localparam logic [RP_W-1:0]  RAMP_RST     = RP_W'(1000);
  localparam logic [SPM_W-1:0] SPM_RST      = SPM_W'(10);
  localparam logic [MIN_W-1:0] MIN_RST      = MIN_W'(5);
  localparam logic [WD_W-1:0]  WATCHDOG_RST = WD_W'(200000);

  // Serial multiplier: multiplicand holds |speed| * pulses_per_mm,
  // multiplier holds since_step + 1
  localparam int MUL_A_W   = CUR_W + SPM_W;
  localparam int MUL_B_W   = STEP_CNT_W + 1;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam logic [MUL_CNT_W-1:0] DEN_LEN = MUL_CNT_W'(SPM_W);
  localparam logic [MUL_CNT_W-1:0] PRD_LEN = MUL_CNT_W'(MUL_B_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_VEL   = 2'd1,
    FUNC_STOP      = 2'd2,
    FUNC_HEARTBEAT = 2'd3
  } func_e;

  typedef struct packed {
    logic [ACC_W-1:0] accel_step;
    logic [RP_W-1:0]  ramp_period;
    logic [SPM_W-1:0] pulses_per_mm;
    logic [MIN_W-1:0] min_speed;
    logic [WD_W-1:0]  watchdog_limit;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
    logic [MUL_CNT_W-1:0] len;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

[rtl/core/ddsr_cfg_regs.sv]
// Configuration register file behind a simple APB-style port.
// Depends on ddsr_pkg for register indexes, reset values and cfg_t.
module ddsr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddsr_pkg::ADDR_W-1:0]   paddr,
  input  logic [ddsr_pkg::DATA_W-1:0]   pwdata,
  output logic [ddsr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ddsr_pkg::cfg_t                cfg_o
);
  import ddsr_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ACCEL:    cfg_d.accel_step     = pwdata[ACC_W-1:0];
        REG_RAMP:     cfg_d.ramp_period    = pwdata[RP_W-1:0];
        REG_SPM:      cfg_d.pulses_per_mm  = pwdata[SPM_W-1:0];
        REG_MIN:      cfg_d.min_speed      = pwdata[MIN_W-1:0];
        REG_WATCHDOG: cfg_d.watchdog_limit = pwdata[WD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACCEL:    prdata = DATA_W'(cfg_q.accel_step);
      REG_RAMP:     prdata = DATA_W'(cfg_q.ramp_period);
      REG_SPM:      prdata = DATA_W'(cfg_q.pulses_per_mm);
      REG_MIN:      prdata = DATA_W'(cfg_q.min_speed);
      REG_WATCHDOG: prdata = DATA_W'(cfg_q.watchdog_limit);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step     <= ACCEL_RST;
      cfg_q.ramp_period    <= RAMP_RST;
      cfg_q.pulses_per_mm  <= SPM_RST;
      cfg_q.min_speed      <= MIN_RST;
      cfg_q.watchdog_limit <= WATCHDOG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/ddsr_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on ddsr_pkg for widths and the request/response structs.
module ddsr_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddsr_pkg::mul_req_t  req_i,
  output ddsr_pkg::mul_rsp_t  rsp_o
);
  import ddsr_pkg::*;

  logic [MUL_P_W-1:0]   p_q, p_d;
  logic [MUL_A_W-1:0]   a_q, a_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [MUL_A_W:0]     acc_sum;

  // add the multiplicand into the upper half when the low bit is set
  assign acc_sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    p_d    = p_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      p_d   = {{MUL_A_W{1'b0}}, req_i.b};
      a_d   = req_i.a;
      cnt_d = req_i.len;
    end else if (cnt_q != '0) begin
      p_d    = {acc_sum, p_q[MUL_B_W-1:1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = p_q;

endmodule

[rtl/core/diff_drive_stepper_ramp_unit.sv]
// Channel   Dir  Handshake              Word
// in        in   in_valid_i/in_stall_o  func, lin_speed, turn_speed
// out       out  out_valid_o/out_stall_i step, dir, speed per wheel, watchdog flag
// cfg       in   APB psel/penable/pwrite accel, ramp period, steps/mm, min speed, watchdog
//
// A command word runs S_EXEC, S_FIN; a tick runs S_EXEC, S_RAMP, then S_CHK per
// wheel, then S_FIN. Per wheel the shared serial multiplier forms |v|*pulses_per_mm
// (8 iterations) and then (since_step+1)*den (21 iterations); a wheel at or below
// min speed, or with zero pulses_per_mm, skips both. One word is in work at a time;
// the input is taken again while the previous result still waits in the output register.
// Reset clears all motion state and loads the register defaults.
// Depends on ddsr_pkg, ddsr_cfg_regs and ddsr_serial_mul.
module diff_drive_stepper_ramp_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ddsr_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [ddsr_pkg::SPD_W-1:0]  lin_speed_i,
  input  logic signed [ddsr_pkg::SPD_W-1:0]  turn_speed_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               step_left_o,
  output logic                               step_right_o,
  output logic                               dir_left_o,
  output logic                               dir_right_o,
  output logic signed [ddsr_pkg::CUR_W-1:0]  speed_left_o,
  output logic signed [ddsr_pkg::CUR_W-1:0]  speed_right_o,
  output logic                               stopped_by_watchdog_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ddsr_pkg::ADDR_W-1:0]        paddr,
  input  logic [ddsr_pkg::DATA_W-1:0]        pwdata,
  output logic [ddsr_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import ddsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_RAMP = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_DEN  = 7'b0010000,
    S_PRD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  function automatic logic signed [CUR_W-1:0] ramp_one(
    input logic signed [CUR_W-1:0] cur,
    input logic signed [CUR_W-1:0] tgt,
    input logic [ACC_W-1:0]        acc
  );
    logic signed [RAMP_W-1:0] c;
    logic signed [RAMP_W-1:0] t;
    logic signed [RAMP_W-1:0] a;
    logic signed [RAMP_W-1:0] d;
    logic [RAMP_W-1:0]        dm;
    c = RAMP_W'(cur);
    t = RAMP_W'(tgt);
    a = $signed({{(RAMP_W-ACC_W){1'b0}}, acc});
    if (c < t) c = c + a;
    if (c > t) c = c - a;
    d  = c - t;
    dm = d[RAMP_W-1] ? RAMP_W'(-d) : RAMP_W'(d);
    // snap when within one step of the target
    if (dm < $unsigned(a)) c = t;
    return c[CUR_W-1:0];
  endfunction

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  state_e state_q, state_d;
  logic   w_q, w_d;

  logic signed [SPD_W-1:0] tl_q, tl_d, tt_q, tt_d;
  logic signed [CUR_W-1:0] cur_q [2];
  logic signed [CUR_W-1:0] cur_d [2];
  logic                    dir_q [2];
  logic                    dir_d [2];
  logic [STEP_CNT_W-1:0]   ss_q [2];
  logic [STEP_CNT_W-1:0]   ss_d [2];
  logic                    step_q [2];
  logic                    step_d [2];
  logic [RP_W-1:0]         sr_q, sr_d;
  logic [WD_W-1:0]         sc_q, sc_d;
  logic                    to_q, to_d;

  func_e                   func_q;
  logic signed [SPD_W-1:0] lin_q, turn_q;

  logic                    out_valid_q, out_valid_d;
  logic                    load_out;
  logic                    out_step_l_q, out_step_r_q, out_dir_l_q, out_dir_r_q, out_to_q;
  logic signed [CUR_W-1:0] out_spd_l_q, out_spd_r_q;

  logic                    accept;
  logic                    wheel_done;
  logic signed [CUR_W-1:0] cur_sel;
  logic [CUR_W-1:0]        mag_sel;
  logic [WD_W-1:0]         sc_inc;
  logic                    wd_fire;
  logic signed [CUR_W-1:0] tgt_l, tgt_r;
  logic [MUL_B_W-1:0]      ss_plus;
  logic [MUL_A_W-1:0]      den;
  logic                    prod_hit;

  ddsr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ddsr_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  assign cur_sel  = cur_q[w_q];
  assign mag_sel  = cur_sel[CUR_W-1] ? CUR_W'(-cur_sel) : CUR_W'(cur_sel);
  assign sc_inc   = (sc_q == '1) ? sc_q : sc_q + 1'b1;
  assign wd_fire  = (sc_inc > cfg.watchdog_limit) && ((tl_q != '0) || (tt_q != '0)) && !to_q;
  assign tgt_l    = $signed({tl_q[SPD_W-1], tl_q}) - $signed({tt_q[SPD_W-1], tt_q});
  assign tgt_r    = $signed({tl_q[SPD_W-1], tl_q}) + $signed({tt_q[SPD_W-1], tt_q});
  assign ss_plus  = {1'b0, ss_q[w_q]} + 1'b1;
  assign den      = mul_rsp.prod[MUL_B_W-SPM_W +: MUL_A_W];
  // step once (since_step + 1) * den exceeds the tick rate
  assign prod_hit = mul_rsp.prod > MUL_P_W'(TICKS_PER_SECOND);

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    tl_d        = tl_q;
    tt_d        = tt_q;
    cur_d       = cur_q;
    dir_d       = dir_q;
    ss_d        = ss_q;
    step_d      = step_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    to_d        = to_q;
    out_valid_d = out_valid_q && out_stall_i;
    load_out    = 1'b0;
    wheel_done  = 1'b0;
    mul_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        w_d       = 1'b0;
        step_d[0] = 1'b0;
        step_d[1] = 1'b0;
        if (func_q == FUNC_TICK) begin
          sc_d = sc_inc;
          sr_d = (sr_q == '1) ? sr_q : sr_q + 1'b1;
          for (int i = 0; i < 2; i++) begin
            ss_d[i] = (ss_q[i] == '1) ? ss_q[i] : ss_q[i] + 1'b1;
          end
          if (wd_fire) begin
            tl_d     = '0;
            tt_d     = '0;
            cur_d[0] = '0;
            cur_d[1] = '0;
            to_d     = 1'b1;
          end
          state_d = S_RAMP;
        end else begin
          sc_d = '0;
          to_d = 1'b0;
          case (func_q)
            FUNC_SET_VEL: begin
              tl_d = lin_q;
              tt_d = turn_q;
            end
            FUNC_STOP: begin
              tl_d     = '0;
              tt_d     = '0;
              cur_d[0] = '0;
              cur_d[1] = '0;
            end
            default: ;
          endcase
          state_d = S_FIN;
        end
      end
      S_RAMP: begin
        if (sr_q > cfg.ramp_period) begin
          sr_d     = '0;
          cur_d[0] = ramp_one(cur_q[0], tgt_l, cfg.accel_step);
          cur_d[1] = ramp_one(cur_q[1], tgt_r, cfg.accel_step);
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        if (mag_sel > CUR_W'(cfg.min_speed)) begin
          dir_d[w_q] = !cur_sel[CUR_W-1];
          if (cfg.pulses_per_mm != '0) begin
            mul_req.start = 1'b1;
            mul_req.a     = MUL_A_W'(mag_sel);
            mul_req.b     = MUL_B_W'(cfg.pulses_per_mm);
            mul_req.len   = DEN_LEN;
            state_d       = S_DEN;
          end else begin
            wheel_done = 1'b1;
          end
        end else begin
          wheel_done = 1'b1;
        end
      end
      S_DEN: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = den;
          mul_req.b     = ss_plus;
          mul_req.len   = PRD_LEN;
          state_d       = S_PRD;
        end
      end
      S_PRD: begin
        if (mul_rsp.done) begin
          if (prod_hit) begin
            step_d[w_q] = 1'b1;
            ss_d[w_q]   = '0;
          end
          wheel_done = 1'b1;
        end
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // advance to the right wheel, or finish after it
    if (wheel_done) begin
      if (w_q) begin
        state_d = S_FIN;
      end else begin
        w_d     = 1'b1;
        state_d = S_CHK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_q         <= 1'b0;
      tl_q        <= '0;
      tt_q        <= '0;
      cur_q[0]    <= '0;
      cur_q[1]    <= '0;
      dir_q[0]    <= 1'b0;
      dir_q[1]    <= 1'b0;
      ss_q[0]     <= '0;
      ss_q[1]     <= '0;
      step_q[0]   <= 1'b0;
      step_q[1]   <= 1'b0;
      sr_q        <= '0;
      sc_q        <= '0;
      to_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      tl_q        <= tl_d;
      tt_q        <= tt_d;
      cur_q       <= cur_d;
      dir_q       <= dir_d;
      ss_q        <= ss_d;
      step_q      <= step_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
      to_q        <= to_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      lin_q  <= lin_speed_i;
      turn_q <= turn_speed_i;
    end
    if (load_out) begin
      out_step_l_q <= step_q[0];
      out_step_r_q <= step_q[1];
      out_dir_l_q  <= dir_q[0];
      out_dir_r_q  <= dir_q[1];
      out_spd_l_q  <= cur_q[0];
      out_spd_r_q  <= cur_q[1];
      out_to_q     <= to_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign step_left_o           = out_step_l_q;
  assign step_right_o          = out_step_r_q;
  assign dir_left_o            = out_dir_l_q;
  assign dir_right_o           = out_dir_r_q;
  assign speed_left_o          = out_spd_l_q;
  assign speed_right_o         = out_spd_r_q;
  assign stopped_by_watchdog_o = out_to_q;

endmodule

[rtl/core/ddsr_checker.sv]
// Port-level checks for the stepper ramp unit, attached by bind.
// Depends on ddsr_pkg and on diff_drive_stepper_ramp_unit's ports.
module ddsr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_i,
  input logic                              out_valid_i,
  input logic                              out_stall_i,
  input logic                              step_left_i,
  input logic                              step_right_i,
  input logic                              dir_left_i,
  input logic                              dir_right_i,
  input logic signed [ddsr_pkg::CUR_W-1:0] speed_left_i,
  input logic signed [ddsr_pkg::CUR_W-1:0] speed_right_i,
  input logic                              stopped_i
);
  import ddsr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(speed_left_i) &&
      $stable(speed_right_i) && $stable(step_left_i) && $stable(step_right_i) &&
      $stable(stopped_i))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input taken while a word is in work");

  // watchdog stop leaves both wheels at rest
  a_wd_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stopped_i |-> (speed_left_i == '0) && (speed_right_i == '0))
    else $error("wheel moving after watchdog stop");

  a_step_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && step_left_i |->
      (speed_left_i != '0) && (dir_left_i == !speed_left_i[CUR_W-1]))
    else $error("left step against speed or direction");

  a_step_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && step_right_i |->
      (speed_right_i != '0) && (dir_right_i == !speed_right_i[CUR_W-1]))
    else $error("right step against speed or direction");

endmodule

bind diff_drive_stepper_ramp_unit ddsr_checker u_ddsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .step_left_i   (step_left_o),
  .step_right_i  (step_right_o),
  .dir_left_i    (dir_left_o),
  .dir_right_i   (dir_right_o),
  .speed_left_i  (speed_left_o),
  .speed_right_i (speed_right_o),
  .stopped_i     (stopped_by_watchdog_o)
);

[dv/diff_drive_stepper_ramp_unit_test.sv]
// Self-checking testbench for diff_drive_stepper_ramp_unit: an in-bench wheel model
// predicts each output word, and randomised traffic and back-pressure run on both channels.
// Depends on ddsr_pkg and the RTL of the unit.
module diff_drive_stepper_ramp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ddsr_pkg::*;

  typedef struct packed {
    logic             step_left;
    logic             step_right;
    logic             dir_left;
    logic             dir_right;
    logic [CUR_W-1:0] speed_left;
    logic [CUR_W-1:0] speed_right;
    logic             watchdog;
  } wheel_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [FUNC_W-1:0]        func_i = FUNC_TICK;
  logic signed [SPD_W-1:0]  lin_speed_i = '0;
  logic signed [SPD_W-1:0]  turn_speed_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     step_left_o;
  logic                     step_right_o;
  logic                     dir_left_o;
  logic                     dir_right_o;
  logic signed [CUR_W-1:0]  speed_left_o;
  logic signed [CUR_W-1:0]  speed_right_o;
  logic                     stopped_by_watchdog_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // Wheel model state and its copy of the registers
  cfg_t                     drive_cfg = '{accel_step: ACCEL_RST, ramp_period: RAMP_RST,
                                          pulses_per_mm: SPM_RST, min_speed: MIN_RST,
                                          watchdog_limit: WATCHDOG_RST};
  logic signed [SPD_W-1:0]  goal_lin = '0;
  logic signed [SPD_W-1:0]  goal_turn = '0;
  int                       wheel_speed [2] = '{0, 0};
  logic                     dir_q [2] = '{1'b0, 1'b0};
  logic [STEP_CNT_W-1:0]    step_age [2] = '{'0, '0};
  logic [RP_W-1:0]          ramp_age = '0;
  logic [WD_W-1:0]          quiet_age = '0;
  logic                     wd_tripped = 1'b0;

  wheel_word_t              expected_words [$];
  int                       fault_count = 0;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  int                       stall_hold = 0;

  diff_drive_stepper_ramp_unit uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .func_i                (func_i),
    .lin_speed_i           (lin_speed_i),
    .turn_speed_i          (turn_speed_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .step_left_o           (step_left_o),
    .step_right_o          (step_right_o),
    .dir_left_o            (dir_left_o),
    .dir_right_o           (dir_right_o),
    .speed_left_o          (speed_left_o),
    .speed_right_o         (speed_right_o),
    .stopped_by_watchdog_o (stopped_by_watchdog_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- wheel model

  function automatic int approach_target(int cur, int tgt);
    int a;
    a = int'(drive_cfg.accel_step);
    if (cur < tgt) cur = cur + a;
    if (cur > tgt) cur = cur - a;
    // snap when closer than one step
    if (((cur > tgt) ? cur - tgt : tgt - cur) < a) cur = tgt;
    return cur;
  endfunction

  function automatic logic wheel_pulse(int w, int v);
    int unsigned m;
    int unsigned den;
    int unsigned delay;
    m = (v < 0) ? -v : v;
    if (m <= drive_cfg.min_speed) return 1'b0;
    dir_q[w] = (v > 0);
    den = m * drive_cfg.pulses_per_mm;
    if (den == 0) return 1'b0;
    delay = TICKS_PER_SECOND / den;
    if (step_age[w] >= delay) begin
      step_age[w] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic wheel_word_t advance_drive(func_e op, logic signed [SPD_W-1:0] lin,
                                                logic signed [SPD_W-1:0] turn);
    wheel_word_t word;
    logic        pulse_l;
    logic        pulse_r;
    pulse_l = 1'b0;
    pulse_r = 1'b0;
    if (op == FUNC_TICK) begin
      // advance the elapsed counters, holding at full scale
      if (quiet_age != '1) quiet_age = quiet_age + 1'b1;
      if (ramp_age != '1) ramp_age = ramp_age + 1'b1;
      for (int w = 0; w < 2; w++)
        if (step_age[w] != '1) step_age[w] = step_age[w] + 1'b1;
      if (quiet_age > drive_cfg.watchdog_limit && (goal_lin != 0 || goal_turn != 0) &&
          !wd_tripped) begin
        goal_lin = '0;
        goal_turn = '0;
        wheel_speed[0] = 0;
        wheel_speed[1] = 0;
        wd_tripped = 1'b1;
      end
      if (ramp_age > drive_cfg.ramp_period) begin
        ramp_age = '0;
        wheel_speed[0] = approach_target(wheel_speed[0], int'(goal_lin) - int'(goal_turn));
        wheel_speed[1] = approach_target(wheel_speed[1], int'(goal_lin) + int'(goal_turn));
      end
      pulse_l = wheel_pulse(0, wheel_speed[0]);
      pulse_r = wheel_pulse(1, wheel_speed[1]);
    end else begin
      quiet_age = '0;
      wd_tripped = 1'b0;
      case (op)
        FUNC_SET_VEL: begin
          goal_lin = lin;
          goal_turn = turn;
        end
        FUNC_STOP: begin
          goal_lin = '0;
          goal_turn = '0;
          wheel_speed[0] = 0;
          wheel_speed[1] = 0;
        end
        default: ;
      endcase
    end
    word.step_left = pulse_l;
    word.step_right = pulse_r;
    word.dir_left = dir_q[0];
    word.dir_right = dir_q[1];
    word.speed_left = CUR_W'(wheel_speed[0]);
    word.speed_right = CUR_W'(wheel_speed[1]);
    word.watchdog = wd_tripped;
    return word;
  endfunction

  // ------------------------------------------------------------ channel drivers

  task automatic send_word(func_e op, logic signed [SPD_W-1:0] lin,
                           logic signed [SPD_W-1:0] turn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    lin_speed_i <= lin;
    turn_speed_i <= turn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(advance_drive(op, lin, turn));
  endtask

  task automatic send_tick();
    send_word(FUNC_TICK, SPD_W'($urandom), SPD_W'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic compare_field(string name, logic signed [15:0] want,
                               logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_word
    wheel_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: output word with none expected, expected nothing, actual speeds %0d %0d",
                 $time, speed_left_o, speed_right_o);
        fault_count++;
      end else begin
        want = expected_words.pop_front();
        compare_field("step_left", want.step_left, step_left_o);
        compare_field("step_right", want.step_right, step_right_o);
        compare_field("dir_left", want.dir_left, dir_left_o);
        compare_field("dir_right", want.dir_right, dir_right_o);
        compare_field("speed_left", $signed(want.speed_left), speed_left_o);
        compare_field("speed_right", $signed(want.speed_right), speed_right_o);
        compare_field("stopped_by_watchdog", want.watchdog, stopped_by_watchdog_o);
      end
    end
  end

  // --------------------------------------------------------------- register port

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACCEL:    drive_cfg.accel_step = val[ACC_W-1:0];
      REG_RAMP:     drive_cfg.ramp_period = val[RP_W-1:0];
      REG_SPM:      drive_cfg.pulses_per_mm = val[SPM_W-1:0];
      REG_MIN:      drive_cfg.min_speed = val[MIN_W-1:0];
      REG_WATCHDOG: drive_cfg.watchdog_limit = val[WD_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic read_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %0d read mismatch, expected %0h, actual %0h",
               $time, idx, want, prdata);
      fault_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_all();
    read_reg(REG_ACCEL, DATA_W'(drive_cfg.accel_step));
    read_reg(REG_RAMP, DATA_W'(drive_cfg.ramp_period));
    read_reg(REG_SPM, DATA_W'(drive_cfg.pulses_per_mm));
    read_reg(REG_MIN, DATA_W'(drive_cfg.min_speed));
    read_reg(REG_WATCHDOG, DATA_W'(drive_cfg.watchdog_limit));
  endtask

  task automatic load_settings(logic [DATA_W-1:0] accel, logic [DATA_W-1:0] period,
                               logic [DATA_W-1:0] spm, logic [DATA_W-1:0] floor_spd,
                               logic [DATA_W-1:0] wd);
    write_reg(REG_ACCEL, accel);
    write_reg(REG_RAMP, period);
    write_reg(REG_SPM, spm);
    write_reg(REG_MIN, floor_spd);
    write_reg(REG_WATCHDOG, wd);
  endtask

  // ----------------------------------------------------------------------- tests

  task automatic test_register_map();
    read_all();
    load_settings('1, '1, '1, '1, '1);
    read_all();
    load_settings('0, '0, '0, '0, '0);
    read_all();
  endtask

  task automatic test_speed_extremes();
    load_settings(255, 1, 255, 0, 24'hFFFFFF);
    send_word(FUNC_SET_VEL, 12'sd2047, -12'sd2048);
    repeat (2) send_tick();
    send_word(FUNC_SET_VEL, -12'sd2048, 12'sd2047);
    repeat (2) send_tick();
    // right wheel target reaches the most negative speed
    send_word(FUNC_SET_VEL, -12'sd2048, -12'sd2048);
    repeat (2) send_tick();
    send_word(FUNC_HEARTBEAT, 12'sd2047, -12'sd2048);
    send_word(FUNC_STOP, -12'sd1, -12'sd1);
    settle();
  endtask

  task automatic test_watchdog();
    load_settings(20, 1, 200, 5, 2);
    send_word(FUNC_SET_VEL, 12'sd200, 12'sd50);
    repeat (2) send_tick();
    // zero targets: no trip while the wheels ramp down
    send_word(FUNC_SET_VEL, 12'sd0, 12'sd0);
    repeat (4) send_tick();
    send_word(FUNC_SET_VEL, -12'sd500, 12'sd100);
    repeat (3) send_tick();
    settle();
  endtask

  task automatic test_zero_gain();
    load_settings(100, 1, 0, 0, 24'hFFFFFF);
    send_word(FUNC_SET_VEL, 12'sd300, -12'sd100);
    repeat (2) send_tick();
    settle();
    write_reg(REG_ACCEL, 0);
    send_word(FUNC_SET_VEL, -12'sd300, 12'sd0);
    repeat (2) send_tick();
    settle();
  endtask

  task automatic test_backpressure();
    load_settings(50, 2, 200, 10, 1000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    stall_hold = 300;
    @(posedge clk_i);
    send_word(FUNC_SET_VEL, 12'sd800, -12'sd200);
    repeat (11) send_tick();
    settle();
  endtask

  task automatic drive_random(int n_items);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_word(FUNC_SET_VEL, SPD_W'($urandom), SPD_W'($urandom));
        sent++;
      end else if (pick < 21) begin
        send_word(FUNC_HEARTBEAT, SPD_W'($urandom), SPD_W'($urandom));
        sent++;
      end else if (pick < 25) begin
        send_word(FUNC_STOP, SPD_W'($urandom), SPD_W'($urandom));
        sent++;
      end else if (pick < 30) begin
        // long silence lets the watchdog trip
        burst = $urandom_range(10, 40);
        repeat (burst) send_tick();
        sent += burst;
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int idle_send [3];
    int idle_recv [3];
    idle_send = '{6, 81, 0};
    idle_recv = '{81, 6, 0};
    for (int r = 0; r < 3; r++) begin
      send_idle_pct = idle_send[r];
      recv_stall_pct = idle_recv[r];
      load_settings($urandom_range(1, 255), $urandom_range(1, 6), $urandom_range(20, 255),
                    $urandom_range(0, 255), $urandom_range(1, 60));
      drive_random(70);
      settle();
      case (r)
        0: load_settings(1, 1, 1, 0, 1);
        1: load_settings(255, 65535, 255, 255, 24'hFFFFFF);
        default: load_settings($urandom_range(1, 255), $urandom_range(1, 6),
                               $urandom_range(20, 255), $urandom_range(0, 255),
                               $urandom_range(1, 60));
      endcase
      drive_random(70);
      settle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    send_idle_pct = 6;
    recv_stall_pct = 81;
    test_register_map();
    test_speed_extremes();
    test_watchdog();
    test_zero_gain();
    test_backpressure();
    test_random_traffic();
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
